[sv/max_segment_tree_first_at_least_defines.svh]
// Assertion macros shared by the max segment tree modules.
// Expects signals named clock and reset in the including scope.
`ifndef MAX_SEGMENT_TREE_FIRST_AT_LEAST_DEFINES_SVH
`define MAX_SEGMENT_TREE_FIRST_AT_LEAST_DEFINES_SVH

// Same-cycle implication.
`define MSTFA_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define MSTFA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/mstfa_pkg.sv]
// Shared constants, types and control structs for the max segment tree.
// No dependencies.
package mstfa_pkg;

   localparam int LEAVES    = 1024;
   localparam int LEVELS    = $clog2(LEAVES);
   localparam int DEPTH     = 2 * LEAVES;
   localparam int ADDR_W    = LEVELS + 1;
   localparam int VALUE_W   = 31;
   localparam int POS_W     = 10;
   localparam int INDEX_W   = 10;
   localparam int POS_EXT_W = (LEVELS > POS_W) ? LEVELS : POS_W;

   localparam logic OP_SET   = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef logic [ADDR_W-1:0]  addr_type;
   typedef logic [VALUE_W-1:0] value_type;

   localparam addr_type ROOT_NODE = addr_type'(1);

   typedef struct packed {
      logic clear;      // reset sweep, one node per cycle
      logic load;       // input transfer
      logic set_leaf;   // write leaf, fetch sibling
      logic set_up;     // write parent max, fetch next sibling
      logic qry_chk;    // compare threshold against root
      logic qry_down;   // one level of descent
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic req_is_set;
      logic set_top;
      logic miss;
      logic leaf_hit;
   } status_type;

endpackage

[sv/max_segment_tree_first_at_least.sv]
// Top level of the max segment tree with leftmost-at-least search.
// Depends on mstfa_pkg, mstfa_ctrl, mstfa_dp (which holds mstfa_ram).
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_ready  | req_operation, req_position, req_value
//   rsp     | out       | rsp_valid/rsp_ready  | rsp_found, rsp_first_index
//
// A set makes one node store access per level on the way from the leaf to the root,
// and produces no response.
// A query reads the store once per level on the way to its response;
// a threshold above the root maximum answers straight after the root check.
// After reset all 2*LEAVES nodes of the store are swept to zero, with req_ready low.
// One item at a time; a waiting response holds req_ready low until it is transferred.
module max_segment_tree_first_at_least (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_operation,
   input  logic [mstfa_pkg::POS_W-1:0]   req_position,
   input  logic [mstfa_pkg::VALUE_W-1:0] req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_found,
   output logic [mstfa_pkg::INDEX_W-1:0] rsp_first_index
);

   mstfa_pkg::cmd_type    cmd;
   mstfa_pkg::status_type status;

   mstfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mstfa_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_operation   (req_operation),
      .req_position    (req_position),
      .req_value       (req_value),
      .cmd             (cmd),
      .status          (status),
      .rsp_found       (rsp_found),
      .rsp_first_index (rsp_first_index)
   );

endmodule

[sv/mstfa_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module mstfa_ram #(
   parameter int WIDTH = 31,
   parameter int DEPTH = 2048,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/mstfa_ctrl.sv]
// Sequencer for the max segment tree: clear sweep, set walk, query descent.
// Depends on mstfa_pkg and the assertion macro header.
`include "max_segment_tree_first_at_least_defines.svh"

module mstfa_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  mstfa_pkg::status_type status,
   output mstfa_pkg::cmd_type    cmd
);

   typedef enum logic [6:0] {
      ST_CLEAR    = 7'b0000001,
      ST_IDLE     = 7'b0000010,
      ST_SET_LEAF = 7'b0000100,
      ST_SET_UP   = 7'b0001000,
      ST_QRY_CHK  = 7'b0010000,
      ST_QRY_DOWN = 7'b0100000,
      ST_RESP     = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = status.req_is_set ? ST_SET_LEAF : ST_QRY_CHK;
         end
         ST_SET_LEAF: begin
            state_in = ST_SET_UP;
         end
         ST_SET_UP: begin
            if (status.set_top) state_in = ST_IDLE;
         end
         ST_QRY_CHK: begin
            state_in = status.miss ? ST_RESP : ST_QRY_DOWN;
         end
         ST_QRY_DOWN: begin
            if (status.leaf_hit) state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);

   always_comb begin
      cmd          = '0;
      cmd.clear    = (state_ff == ST_CLEAR);
      cmd.load     = (state_ff == ST_IDLE) && req_valid;
      cmd.set_leaf = (state_ff == ST_SET_LEAF);
      cmd.set_up   = (state_ff == ST_SET_UP);
      cmd.qry_chk  = (state_ff == ST_QRY_CHK);
      cmd.qry_down = (state_ff == ST_QRY_DOWN);
   end

   `MSTFA_ASSERT_IMPL(a_ready_excl, rsp_valid, !req_ready, "input ready while a response waits")
   `MSTFA_ASSERT_NEXT(a_set_done, (state_ff == ST_SET_UP) && status.set_top, req_ready, "set walk did not end after root update")
   `MSTFA_ASSERT_NEXT(a_query_path, cmd.load && !status.req_is_set, state_ff == ST_QRY_CHK, "query transfer did not start root check")

endmodule

[sv/mstfa_dp.sv]
// Datapath for the max segment tree: node store, node pointer, compare and result.
// Depends on mstfa_pkg, mstfa_ram and the assertion macro header.
`include "max_segment_tree_first_at_least_defines.svh"

module mstfa_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_operation,
   input  logic [mstfa_pkg::POS_W-1:0]          req_position,
   input  logic [mstfa_pkg::VALUE_W-1:0]        req_value,
   input  mstfa_pkg::cmd_type                    cmd,
   output mstfa_pkg::status_type                 status,
   output logic                                 rsp_found,
   output logic [mstfa_pkg::INDEX_W-1:0]        rsp_first_index
);

   localparam int AW = mstfa_pkg::ADDR_W;

   mstfa_pkg::addr_type  clr_cnt_ff, clr_cnt_in;
   mstfa_pkg::addr_type  node_ff, node_in;
   mstfa_pkg::value_type value_ff, value_in;
   logic                 found_ff, found_in;
   logic [mstfa_pkg::INDEX_W-1:0] index_ff, index_in;

   logic                 wr_en;
   mstfa_pkg::addr_type  wr_addr, rd_addr;
   mstfa_pkg::value_type wr_data, rd_data;

   mstfa_pkg::addr_type  parent, child, leaf;
   mstfa_pkg::value_type up_max;
   logic                 val_gt;
   logic [mstfa_pkg::POS_EXT_W-1:0] pos_ext, idx_ext;

   mstfa_ram #(
      .WIDTH (mstfa_pkg::VALUE_W),
      .DEPTH (mstfa_pkg::DEPTH)
   ) u_tree (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // rd_data is the sibling during set, root during check, left child during descent
   assign val_gt  = value_ff > rd_data;
   assign up_max  = val_gt ? value_ff : rd_data;
   assign parent  = {1'b0, node_ff[AW-1:1]};
   assign child   = {node_ff[AW-2:0], val_gt};
   assign pos_ext = mstfa_pkg::POS_EXT_W'(req_position);
   assign leaf    = {1'b1, pos_ext[mstfa_pkg::LEVELS-1:0]};
   assign idx_ext = mstfa_pkg::POS_EXT_W'(child[mstfa_pkg::LEVELS-1:0]);

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = clr_cnt_ff;
      wr_data = '0;
      rd_addr = mstfa_pkg::ROOT_NODE;   // idle keeps the root on the read port
      priority if (cmd.clear) begin
         wr_en = 1'b1;
      end else if (cmd.set_leaf) begin
         wr_en   = 1'b1;
         wr_addr = node_ff;
         wr_data = value_ff;
         rd_addr = node_ff ^ mstfa_pkg::addr_type'(1);
      end else if (cmd.set_up) begin
         wr_en   = 1'b1;
         wr_addr = parent;
         wr_data = up_max;
         rd_addr = parent ^ mstfa_pkg::addr_type'(1);
      end else if (cmd.qry_chk) begin
         rd_addr = {node_ff[AW-2:0], 1'b0};
      end else if (cmd.qry_down) begin
         rd_addr = {child[AW-2:0], 1'b0};
      end else begin
         rd_addr = mstfa_pkg::ROOT_NODE;
      end
   end

   always_comb begin
      status            = '0;
      status.clr_last   = (clr_cnt_ff == '1);
      status.req_is_set = (req_operation == mstfa_pkg::OP_SET);
      status.set_top    = (parent == mstfa_pkg::ROOT_NODE);
      status.miss       = val_gt;
      status.leaf_hit   = node_ff[AW-2];
   end

   always_comb begin
      clr_cnt_in = cmd.clear ? clr_cnt_ff + mstfa_pkg::addr_type'(1) : clr_cnt_ff;
      node_in    = node_ff;
      value_in   = value_ff;
      found_in   = found_ff;
      index_in   = index_ff;
      priority if (cmd.load) begin
         value_in = req_value;
         node_in  = status.req_is_set ? leaf : mstfa_pkg::ROOT_NODE;
      end else if (cmd.set_up) begin
         value_in = up_max;
         node_in  = parent;
      end else if (cmd.qry_chk) begin
         if (val_gt) begin
            found_in = 1'b0;
            index_in = '0;
         end
      end else if (cmd.qry_down) begin
         node_in = child;
         if (node_ff[AW-2]) begin
            found_in = 1'b1;
            index_in = idx_ext[mstfa_pkg::INDEX_W-1:0];
         end
      end else begin
         node_in = node_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else begin
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      node_ff  <= node_in;
      value_ff <= value_in;
      found_ff <= found_in;
      index_ff <= index_in;
   end

   assign rsp_found       = found_ff;
   assign rsp_first_index = index_ff;

   `MSTFA_ASSERT_NEXT(a_miss_result, cmd.qry_chk && status.miss, !found_ff && (index_ff == '0), "miss did not clear the result")

endmodule

[test/tb_max_segment_tree_first_at_least.sv]
`timescale 1ns / 1ps
// Testbench for max_segment_tree_first_at_least: directed and random set/query traffic checked
// against an in-bench max-tree predictor. Depends on mstfa_pkg and the DUT sources.
module tb_max_segment_tree_first_at_least;

   localparam int WATCHDOG_LIMIT = 10000;
   localparam int HOLD_CYCLES    = 400;
   localparam int DRAIN_CYCLES   = 40;
   localparam mstfa_pkg::value_type VALUE_MAX = '1;

   typedef struct packed {
      logic                          found;
      logic [mstfa_pkg::INDEX_W-1:0] first_index;
   } answer_type;

   logic                          clock           = 1'b0;
   logic                          reset           = 1'b1;
   logic                          req_valid       = 1'b0;
   logic                          req_operation   = mstfa_pkg::OP_SET;
   logic [mstfa_pkg::POS_W-1:0]   req_position    = '0;
   mstfa_pkg::value_type          req_value       = '0;
   logic                          rsp_ready       = 1'b0;
   logic                          req_ready;
   logic                          rsp_valid;
   logic                          rsp_found;
   logic [mstfa_pkg::INDEX_W-1:0] rsp_first_index;

   // predictor state: node 1 is the root, leaf i sits at node LEAVES+i
   mstfa_pkg::value_type node_max [mstfa_pkg::DEPTH] = '{default: '0};
   answer_type pending_answers [$];
   int         failures     = 0;
   bit         idle_on      = 1'b1;
   logic       hold_request = 1'b0;

   always #4 clock = ~clock;

   max_segment_tree_first_at_least DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_operation   (req_operation),
      .req_position    (req_position),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_found       (rsp_found),
      .rsp_first_index (rsp_first_index)
   );

   function automatic void write_leaf(logic [mstfa_pkg::POS_W-1:0] pos,
                                      mstfa_pkg::value_type val);
      int node;
      node = mstfa_pkg::LEAVES + (int'(pos) % mstfa_pkg::LEAVES);
      node_max[node] = val;
      for (node = node >> 1; node >= 1; node = node >> 1)
         node_max[node] = (node_max[2*node] > node_max[2*node+1]) ?
                          node_max[2*node] : node_max[2*node+1];
   endfunction

   function automatic answer_type first_at_least(mstfa_pkg::value_type threshold);
      answer_type ans;
      int node;
      ans = '0;
      if (threshold <= node_max[mstfa_pkg::ROOT_NODE]) begin
         node = 1;
         while (node < mstfa_pkg::LEAVES)
            node = (node_max[2*node] >= threshold) ? 2*node : 2*node + 1;
         ans.found       = 1'b1;
         ans.first_index = mstfa_pkg::INDEX_W'(node - mstfa_pkg::LEAVES);
      end
      return ans;
   endfunction

   // one input transfer; the predictor is updated when it is accepted
   task automatic send_item(input logic op, input logic [mstfa_pkg::POS_W-1:0] pos,
                            input mstfa_pkg::value_type val);
      while (idle_on && $urandom_range(99) < 16) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_position  <= pos;
      req_value     <= val;
      do @(posedge clock); while (!req_ready);
      if (op == mstfa_pkg::OP_SET)
         write_leaf(pos, val);
      else
         pending_answers.push_back(first_at_least(val));
   endtask

   function automatic mstfa_pkg::value_type pick_threshold();
      mstfa_pkg::value_type leaf;
      leaf = node_max[mstfa_pkg::LEAVES + $urandom_range(mstfa_pkg::LEAVES-1)];
      case ($urandom_range(6))
         0:       return mstfa_pkg::value_type'($urandom());
         1, 2:    return leaf;
         3:       return leaf + 1'b1;
         4:       return node_max[mstfa_pkg::ROOT_NODE];
         5:       return node_max[mstfa_pkg::ROOT_NODE] + 1'b1;
         default: return mstfa_pkg::value_type'($urandom_range(15));
      endcase
   endfunction

   task automatic random_item();
      logic [mstfa_pkg::POS_W-1:0] pos;
      mstfa_pkg::value_type        val;
      case ($urandom_range(3))
         0:       pos = mstfa_pkg::POS_W'($urandom_range(31));
         1:       pos = mstfa_pkg::POS_W'(mstfa_pkg::LEAVES - 1 - $urandom_range(31));
         default: pos = mstfa_pkg::POS_W'($urandom());
      endcase
      if ($urandom_range(99) < 60) begin
         case ($urandom_range(5))
            0:       val = '0;
            1:       val = VALUE_MAX;
            2, 3:    val = mstfa_pkg::value_type'($urandom_range(15));
            default: val = mstfa_pkg::value_type'($urandom());
         endcase
         send_item(mstfa_pkg::OP_SET, pos, val);
      end else begin
         send_item(mstfa_pkg::OP_QUERY, pos, pick_threshold());
      end
   endtask

   task automatic test_empty_store();
      send_item(mstfa_pkg::OP_QUERY, '1, '0);        // zero threshold always hits leaf 0
      send_item(mstfa_pkg::OP_QUERY, '0, 31'd1);
      send_item(mstfa_pkg::OP_QUERY, '1, VALUE_MAX);
   endtask

   task automatic test_field_extremes();
      send_item(mstfa_pkg::OP_SET,   mstfa_pkg::POS_W'(mstfa_pkg::LEAVES-1), VALUE_MAX);
      send_item(mstfa_pkg::OP_QUERY, '0, VALUE_MAX);
      send_item(mstfa_pkg::OP_QUERY, '1, '0);
      send_item(mstfa_pkg::OP_SET,   '0, 31'd1);
      send_item(mstfa_pkg::OP_QUERY, '0, 31'd1);
      send_item(mstfa_pkg::OP_QUERY, '0, 31'd2);
      send_item(mstfa_pkg::OP_SET,   mstfa_pkg::POS_W'(512), 31'h4000_0000);
      send_item(mstfa_pkg::OP_QUERY, '0, 31'h4000_0000);
      send_item(mstfa_pkg::OP_QUERY, '0, 31'h3FFF_FFFF);
      send_item(mstfa_pkg::OP_SET,   mstfa_pkg::POS_W'(mstfa_pkg::LEAVES-1), '0);
      send_item(mstfa_pkg::OP_QUERY, '0, VALUE_MAX);
      send_item(mstfa_pkg::OP_SET,   mstfa_pkg::POS_W'(511), 31'h5555_5555);
      send_item(mstfa_pkg::OP_SET,   mstfa_pkg::POS_W'(512), 31'h2AAA_AAAA);
      send_item(mstfa_pkg::OP_QUERY, 10'h2AA, 31'h2AAA_AAAA);
      send_item(mstfa_pkg::OP_QUERY, 10'h155, 31'h5555_5556);
      send_item(mstfa_pkg::OP_SET,   '0, '0);
      send_item(mstfa_pkg::OP_QUERY, '0, 31'd1);
   endtask

   task automatic test_random_mix(input int count);
      idle_on = 1'b1;
      repeat (count) random_item();
   endtask

   task automatic test_no_idle(input int count);
      idle_on = 1'b0;
      repeat (count) random_item();
      idle_on = 1'b1;
   endtask

   // receiver stops for a long while; queries keep coming so the input stalls
   task automatic test_receiver_holdoff(input int count);
      hold_request <= 1'b1;
      repeat (count)
         send_item(mstfa_pkg::OP_QUERY, mstfa_pkg::POS_W'($urandom()), pick_threshold());
   endtask

   // many equal small values, so the leftmost choice matters
   task automatic test_dense_ties();
      for (int i = 0; i < 64; i++)
         send_item(mstfa_pkg::OP_SET, mstfa_pkg::POS_W'(i),
                   mstfa_pkg::value_type'($urandom_range(3)));
      repeat (16)
         send_item(mstfa_pkg::OP_QUERY, mstfa_pkg::POS_W'($urandom()),
                   mstfa_pkg::value_type'($urandom_range(4)));
   endtask

   initial begin : stimulus
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_store();
      test_field_extremes();
      test_random_mix(1150);
      test_no_idle(250);
      test_receiver_holdoff(60);
      test_dense_ties();
      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("[max_segment_tree_first_at_least] OK");
      else
         $display("[max_segment_tree_first_at_least] ERROR");
      $finish;
   end

   initial begin : receiver
      bit hold_done;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_ready <= !idle_on || ($urandom_range(99) >= 16);
         end
      end
   end

   initial begin : response_checker
      answer_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (pending_answers.size() == 0) begin
               failures++;
               if (failures <= 10)
                  $display("unexpected response: found=%0d first_index=%0d",
                           rsp_found, rsp_first_index);
            end else begin
               want = pending_answers.pop_front();
               if (rsp_found !== want.found || rsp_first_index !== want.first_index) begin
                  failures++;
                  if (failures <= 10)
                     $display({"mismatch: expected found=%0d first_index=%0d, ",
                               "got found=%0d first_index=%0d"},
                              want.found, want.first_index, rsp_found, rsp_first_index);
               end
            end
         end
      end
   end

   initial begin : watchdog
      int stalled_cycles;
      stalled_cycles = 0;
      while (stalled_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            stalled_cycles = 0;
         else
            stalled_cycles++;
      end
      $display("[max_segment_tree_first_at_least] ERROR");
      $finish;
   end

endmodule
